[design/keyboard_layer_stack_macros.svh]
// Assertion macros used by the keyboard layer stack top-level design file.
`ifndef KEYBOARD_LAYER_STACK_MACROS_SVH
`define KEYBOARD_LAYER_STACK_MACROS_SVH

// Same-cycle implication, checked while reset is released.
`define KLS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while reset is released.
`define KLS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/kls_pkg.sv]
package kls_pkg;

    // Default sizes of the layer mask and of the keymap.
    localparam int MASK_BITS_DEF  = 32;
    localparam int MAP_LAYERS_DEF = 8;
    localparam int ROWS_DEF       = 8;
    localparam int COLS_DEF       = 16;

    localparam int CODE_W    = 16;
    localparam int LAYER_W   = 5;
    localparam int OUT_MASK_W = 32;
    localparam int USED_W    = 4;
    localparam int PREFIX_W  = 8;

    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 56;
    localparam int M_TUSER_W = 1;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Command queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_W-1:0] CFG_LAYERS_IN_USE = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TRANSPARENT   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MOMENTARY     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_TOGGLE        = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_MOVE          = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEFAULT       = 3'd5;

    localparam logic [USED_W-1:0]   RST_LAYERS_IN_USE = 4'd8;
    localparam logic [CODE_W-1:0]   RST_TRANSPARENT   = 16'd1;
    localparam logic [PREFIX_W-1:0] RST_MOMENTARY     = 8'd81;
    localparam logic [PREFIX_W-1:0] RST_TOGGLE        = 8'd83;
    localparam logic [PREFIX_W-1:0] RST_MOVE          = 8'd80;
    localparam logic [PREFIX_W-1:0] RST_DEFAULT       = 8'd82;

    // Request kinds carried in s_tuser.
    localparam logic [S_TUSER_W-1:0] REQ_WRITE  = 2'd0;
    localparam logic [S_TUSER_W-1:0] REQ_EVENT  = 2'd1;
    localparam logic [S_TUSER_W-1:0] REQ_LOOKUP = 2'd2;

    typedef enum logic [3:0] {
        OP_KEEP,
        OP_WRITE,
        OP_LOOKUP,
        OP_SET,
        OP_CLEAR,
        OP_FLIP,
        OP_MOVE,
        OP_CLEAR_ALL,
        OP_BASE,
        OP_UNHANDLED
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic [CODE_W-1:0]   code;
        logic [LAYER_W-1:0]  layer;
        logic [2:0]          row;
        logic [3:0]          col;
        logic                in_range;
    } cmd_t;

    typedef struct packed {
        logic [USED_W-1:0]   used;
        logic [CODE_W-1:0]   transparent;
        logic [PREFIX_W-1:0] momentary;
        logic [PREFIX_W-1:0] toggle;
        logic [PREFIX_W-1:0] move;
        logic [PREFIX_W-1:0] dflt;
    } cfg_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_CHECK,
        ST_BASE,
        ST_DONE
    } state_t;

endpackage

[design/keyboard_layer_stack.sv]
// Keyboard layer stack: keeps the active-layer mask, the default layer and a
// keymap of MAP_LAYERS x ROWS x COLS keycodes. Each accepted transaction gives
// exactly one result. A keymap write or a key event goes from the back end
// picking it up through EXEC and DONE to the result register; a lookup reads
// one active, in-use layer at a time through the single keymap read port, in
// SCAN and CHECK per layer (at most min(layers_in_use, MAP_LAYERS) of them),
// and SCAN, BASE when it falls back to the default layer. A two-entry command
// queue lets new transactions be accepted while a lookup runs or a result
// waits. The keymap is not cleared at reset; read only entries written before.
`include "keyboard_layer_stack_macros.svh"

module keyboard_layer_stack #(
    parameter int MASK_BITS  = kls_pkg::MASK_BITS_DEF,
    parameter int MAP_LAYERS = kls_pkg::MAP_LAYERS_DEF,
    parameter int ROWS       = kls_pkg::ROWS_DEF,
    parameter int COLS       = kls_pkg::COLS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // key_code[15:0], pressed[16], key_row[19:17], key_col[23:20], map_layer[26:24]
    input  logic [kls_pkg::S_TDATA_W-1:0]     s_tdata,
    // req_type[1:0]
    input  logic [kls_pkg::S_TUSER_W-1:0]     s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // found_code[15:0], top_layer[20:16], active_mask[52:21]
    output logic [kls_pkg::M_TDATA_W-1:0]     m_tdata,
    // not_handled[0]
    output logic [kls_pkg::M_TUSER_W-1:0]     m_tuser,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [kls_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [kls_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic [kls_pkg::USED_W-1:0]   layers_reg;
    logic [kls_pkg::CODE_W-1:0]   transparent_reg;
    logic [kls_pkg::PREFIX_W-1:0] momentary_reg;
    logic [kls_pkg::PREFIX_W-1:0] toggle_reg;
    logic [kls_pkg::PREFIX_W-1:0] move_reg;
    logic [kls_pkg::PREFIX_W-1:0] dflt_reg;

    kls_pkg::cfg_t       cfg;
    kls_pkg::cmd_t       front_cmd;
    kls_pkg::cmd_t       q_head;
    kls_pkg::q_status_t  q_st;
    logic                q_push;
    logic                q_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            layers_reg      <= kls_pkg::RST_LAYERS_IN_USE;
            transparent_reg <= kls_pkg::RST_TRANSPARENT;
            momentary_reg   <= kls_pkg::RST_MOMENTARY;
            toggle_reg      <= kls_pkg::RST_TOGGLE;
            move_reg        <= kls_pkg::RST_MOVE;
            dflt_reg        <= kls_pkg::RST_DEFAULT;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                kls_pkg::CFG_LAYERS_IN_USE: layers_reg      <= cfg_data[3:0];
                kls_pkg::CFG_TRANSPARENT:   transparent_reg <= cfg_data;
                kls_pkg::CFG_MOMENTARY:     momentary_reg   <= cfg_data[7:0];
                kls_pkg::CFG_TOGGLE:        toggle_reg      <= cfg_data[7:0];
                kls_pkg::CFG_MOVE:          move_reg        <= cfg_data[7:0];
                kls_pkg::CFG_DEFAULT:       dflt_reg        <= cfg_data[7:0];
                default: begin
                    layers_reg <= layers_reg;
                end
            endcase
        end
    end

    // Layers in use never exceed the keymap depth.
    assign cfg.used = (32'(layers_reg) > MAP_LAYERS) ? kls_pkg::USED_W'(MAP_LAYERS)
                                                     : layers_reg;
    assign cfg.transparent = transparent_reg;
    assign cfg.momentary   = momentary_reg;
    assign cfg.toggle      = toggle_reg;
    assign cfg.move        = move_reg;
    assign cfg.dflt        = dflt_reg;

    kls_front #(
        .MASK_BITS  (MASK_BITS),
        .MAP_LAYERS (MAP_LAYERS),
        .ROWS       (ROWS),
        .COLS       (COLS)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cfg      (cfg),
        .q_st     (q_st),
        .push     (q_push),
        .cmd      (front_cmd)
    );

    kls_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (front_cmd),
        .pop      (q_pop),
        .head     (q_head),
        .q_st     (q_st)
    );

    kls_back #(
        .MASK_BITS  (MASK_BITS),
        .MAP_LAYERS (MAP_LAYERS),
        .ROWS       (ROWS),
        .COLS       (COLS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .head     (q_head),
        .q_st     (q_st),
        .pop      (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // The reported top layer is the highest set bit whenever the mask is not empty.
    `KLS_ASSERT_NOW(a_top_layer, aclk, aresetn, m_tvalid && (m_tdata[52:21] != 32'd0), (m_tdata[52:21] >> m_tdata[20:16]) == 32'd1, "top_layer is not the highest active layer")
    // Unhandled key events never carry a resolved keycode.
    `KLS_ASSERT_NOW(a_nh_found, aclk, aresetn, m_tvalid && m_tuser[0], m_tdata[15:0] == 16'd0, "unhandled event carries a keycode")
    // An accepted transaction is held in the command queue on the next cycle.
    `KLS_ASSERT_NEXT(a_queue_hold, aclk, aresetn, q_push, !q_st.empty, "accepted transaction lost from the queue")

endmodule

[design/kls_front.sv]
module kls_front #(
    parameter int MASK_BITS  = kls_pkg::MASK_BITS_DEF,
    parameter int MAP_LAYERS = kls_pkg::MAP_LAYERS_DEF,
    parameter int ROWS       = kls_pkg::ROWS_DEF,
    parameter int COLS       = kls_pkg::COLS_DEF
) (
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [kls_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [kls_pkg::S_TUSER_W-1:0]   s_tuser,
    input  kls_pkg::cfg_t                   cfg,
    input  kls_pkg::q_status_t              q_st,
    output logic                            push,
    output kls_pkg::cmd_t                   cmd
);

    logic [kls_pkg::CODE_W-1:0] key_code;
    logic                       pressed;
    logic [2:0]                 key_row;
    logic [3:0]                 key_col;
    logic [2:0]                 map_layer;
    logic [7:0]                 prefix;
    logic [7:0]                 ev_layer;
    logic                       fits;
    logic                       pos_ok;
    logic                       map_ok;

    assign key_code  = s_tdata[15:0];
    assign pressed   = s_tdata[16];
    assign key_row   = s_tdata[19:17];
    assign key_col   = s_tdata[23:20];
    assign map_layer = s_tdata[26:24];

    assign prefix   = key_code[15:8];
    assign ev_layer = key_code[7:0];
    assign fits     = 32'(ev_layer) < MASK_BITS;
    assign pos_ok   = (32'(key_row) < ROWS) && (32'(key_col) < COLS);
    assign map_ok   = 32'(map_layer) < MAP_LAYERS;

    assign s_tready = !q_st.full;
    assign push     = s_tvalid && s_tready;

    // Prefix priority is momentary, toggle, move-to, then set-default.
    always_comb begin
        cmd.op       = kls_pkg::OP_KEEP;
        cmd.code     = key_code;
        cmd.layer    = ev_layer[kls_pkg::LAYER_W-1:0];
        cmd.row      = key_row;
        cmd.col      = key_col;
        cmd.in_range = pos_ok;
        case (s_tuser)
            kls_pkg::REQ_WRITE: begin
                cmd.op       = kls_pkg::OP_WRITE;
                cmd.layer    = {2'b00, map_layer};
                cmd.in_range = pos_ok && map_ok;
            end
            kls_pkg::REQ_LOOKUP: begin
                cmd.op = kls_pkg::OP_LOOKUP;
            end
            kls_pkg::REQ_EVENT: begin
                if (prefix == cfg.momentary) begin
                    if (fits) begin
                        cmd.op = pressed ? kls_pkg::OP_SET : kls_pkg::OP_CLEAR;
                    end
                end else if (prefix == cfg.toggle) begin
                    if (pressed && fits) begin
                        cmd.op = kls_pkg::OP_FLIP;
                    end
                end else if (prefix == cfg.move) begin
                    if (pressed) begin
                        cmd.op = fits ? kls_pkg::OP_MOVE : kls_pkg::OP_CLEAR_ALL;
                    end
                end else if (prefix == cfg.dflt) begin
                    if (pressed && (ev_layer < {4'b0000, cfg.used})) begin
                        cmd.op = kls_pkg::OP_BASE;
                    end
                end else begin
                    cmd.op = kls_pkg::OP_UNHANDLED;
                end
            end
            default: begin
                cmd.op = kls_pkg::OP_KEEP;
            end
        endcase
    end

endmodule

[design/kls_queue.sv]
module kls_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  kls_pkg::cmd_t       push_cmd,
    input  logic                pop,
    output kls_pkg::cmd_t       head,
    output kls_pkg::q_status_t  q_st
);

    kls_pkg::cmd_t                entries [kls_pkg::QUEUE_DEPTH];
    logic [kls_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [kls_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [kls_pkg::QCNT_W-1:0]   count_reg, count_next;

    assign head     = entries[rd_ptr_reg];
    assign q_st.empty = (count_reg == '0);
    assign q_st.full  = (count_reg == kls_pkg::QCNT_W'(kls_pkg::QUEUE_DEPTH));

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[design/kls_back.sv]
module kls_back #(
    parameter int MASK_BITS  = kls_pkg::MASK_BITS_DEF,
    parameter int MAP_LAYERS = kls_pkg::MAP_LAYERS_DEF,
    parameter int ROWS       = kls_pkg::ROWS_DEF,
    parameter int COLS       = kls_pkg::COLS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  kls_pkg::cfg_t                   cfg,
    input  kls_pkg::cmd_t                   head,
    input  kls_pkg::q_status_t              q_st,
    output logic                            pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [kls_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic [kls_pkg::M_TUSER_W-1:0]   m_tuser
);

    localparam int DEPTH  = MAP_LAYERS * ROWS * COLS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    kls_pkg::state_t               state_reg, state_next;
    kls_pkg::cmd_t                 cmd_reg;
    logic [MASK_BITS-1:0]          mask_reg, mask_next;
    logic [kls_pkg::LAYER_W-1:0]   base_reg, base_next;
    logic [MAP_LAYERS-1:0]         remaining_reg;
    logic [kls_pkg::CODE_W-1:0]    found_reg;
    logic                          nh_reg;
    logic [kls_pkg::CODE_W-1:0]    rd_data_reg;
    logic                          m_tvalid_reg;
    logic [kls_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic [kls_pkg::M_TUSER_W-1:0] m_tuser_reg;

    logic [kls_pkg::CODE_W-1:0]    keymap [DEPTH];

    logic [kls_pkg::OUT_MASK_W-1:0] mask_ext;
    logic [MASK_BITS-1:0]           op_bit;
    logic [MAP_LAYERS-1:0]          cand;
    logic                           any_cand;
    logic [kls_pkg::LAYER_W-1:0]    pick;
    logic [kls_pkg::LAYER_W-1:0]    top_layer;
    logic                           out_free;
    logic                           mem_we;
    logic                           rd_en;
    logic                           load_out;
    logic [ADDR_W-1:0]              rd_addr;
    logic [ADDR_W-1:0]              wr_addr;

    function automatic logic [ADDR_W-1:0] addr_of(
        input logic [kls_pkg::LAYER_W-1:0] lay,
        input logic [2:0]                  row,
        input logic [3:0]                  col
    );
        addr_of = ADDR_W'((32'(lay) * ROWS + 32'(row)) * COLS + 32'(col));
    endfunction

    assign mask_ext = kls_pkg::OUT_MASK_W'(mask_reg);
    assign op_bit   = MASK_BITS'(1) << cmd_reg.layer;
    assign out_free = !m_tvalid_reg || m_tready;

    // Layers still to visit in a lookup: active, in use and not yet read.
    always_comb begin
        for (int l = 0; l < MAP_LAYERS; l++) begin
            cand[l] = mask_ext[l] && (l < 32'(cfg.used)) && remaining_reg[l];
        end
    end

    always_comb begin
        any_cand = 1'b0;
        pick     = '0;
        for (int l = 0; l < MAP_LAYERS; l++) begin
            if (cand[l]) begin
                any_cand = 1'b1;
                pick     = kls_pkg::LAYER_W'(l);
            end
        end
    end

    always_comb begin
        top_layer = base_reg;
        for (int l = 0; l < MASK_BITS; l++) begin
            if (mask_reg[l]) begin
                top_layer = kls_pkg::LAYER_W'(l);
            end
        end
    end

    assign rd_addr = any_cand ? addr_of(pick, cmd_reg.row, cmd_reg.col)
                              : addr_of(base_reg, cmd_reg.row, cmd_reg.col);
    assign wr_addr = addr_of(cmd_reg.layer, cmd_reg.row, cmd_reg.col);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            kls_pkg::ST_IDLE: begin
                if (!q_st.empty) begin
                    state_next = kls_pkg::ST_EXEC;
                end
            end
            kls_pkg::ST_EXEC: begin
                if (cmd_reg.op == kls_pkg::OP_LOOKUP && cmd_reg.in_range) begin
                    state_next = kls_pkg::ST_SCAN;
                end else begin
                    state_next = kls_pkg::ST_DONE;
                end
            end
            kls_pkg::ST_SCAN: begin
                state_next = any_cand ? kls_pkg::ST_CHECK : kls_pkg::ST_BASE;
            end
            kls_pkg::ST_CHECK: begin
                if (rd_data_reg != cfg.transparent) begin
                    state_next = kls_pkg::ST_DONE;
                end else begin
                    state_next = kls_pkg::ST_SCAN;
                end
            end
            kls_pkg::ST_BASE: begin
                state_next = kls_pkg::ST_DONE;
            end
            kls_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = kls_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = kls_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        pop      = 1'b0;
        mem_we   = 1'b0;
        rd_en    = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            kls_pkg::ST_IDLE:  pop = !q_st.empty;
            kls_pkg::ST_EXEC:  mem_we = (cmd_reg.op == kls_pkg::OP_WRITE) && cmd_reg.in_range;
            kls_pkg::ST_SCAN:  rd_en = 1'b1;
            kls_pkg::ST_DONE:  load_out = out_free;
            default: begin
                pop = 1'b0;
            end
        endcase
    end

    always_comb begin
        mask_next = mask_reg;
        base_next = base_reg;
        if (state_reg == kls_pkg::ST_EXEC) begin
            case (cmd_reg.op)
                kls_pkg::OP_SET:       mask_next = mask_reg | op_bit;
                kls_pkg::OP_CLEAR:     mask_next = mask_reg & ~op_bit;
                kls_pkg::OP_FLIP:      mask_next = mask_reg ^ op_bit;
                kls_pkg::OP_MOVE:      mask_next = op_bit;
                kls_pkg::OP_CLEAR_ALL: mask_next = '0;
                kls_pkg::OP_BASE:      base_next = cmd_reg.layer;
                default: begin
                    mask_next = mask_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= kls_pkg::ST_IDLE;
            mask_reg     <= '0;
            base_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            mask_reg  <= mask_next;
            base_reg  <= base_next;
            if (load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            kls_pkg::ST_IDLE: begin
                if (pop) begin
                    cmd_reg       <= head;
                    found_reg     <= '0;
                    nh_reg        <= 1'b0;
                    remaining_reg <= '1;
                end
            end
            kls_pkg::ST_EXEC: begin
                if (cmd_reg.op == kls_pkg::OP_UNHANDLED) begin
                    nh_reg <= 1'b1;
                end
            end
            kls_pkg::ST_SCAN: begin
                if (any_cand) begin
                    remaining_reg <= remaining_reg & ~(MAP_LAYERS'(1) << pick);
                end
            end
            kls_pkg::ST_CHECK: begin
                if (rd_data_reg != cfg.transparent) begin
                    found_reg <= rd_data_reg;
                end
            end
            kls_pkg::ST_BASE: begin
                found_reg <= rd_data_reg;
            end
            default: begin
                found_reg <= found_reg;
            end
        endcase
        if (load_out) begin
            m_tdata_reg <= {mask_ext, top_layer, found_reg};
            m_tuser_reg <= nh_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            keymap[wr_addr] <= cmd_reg.code;
        end
        if (rd_en) begin
            rd_data_reg <= keymap[rd_addr];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
